### hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int AW     = 12;   // cell index, covers the largest store
  localparam int IN_AW  = 13;   // raw row*COLUMNS+column before range check

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] TAB_MASK   = ~8'd7;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_PRINT,
    K_NEWLINE,
    K_CR,
    K_BS,
    K_TAB,
    K_WRITE,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SCROLL,
    ST_SFILL,
    ST_FILL
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic [7:0]      ch;
    logic [7:0]      attr;
    logic [AW-1:0]   addr;
    logic            oor;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic              out_of_range;
  } result_t;

endpackage

### hw/rtl/text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Text console engine: cell store, cursor, control characters and scrolling.
//
//   channel   direction  handshake        payload
//   in_*      input      push / full      action, char_code, column, row, attr
//   out_*     output     empty / pop      cell_data, cursor, offset, range flag
//   cfg_*     input      valid / ready    text color
//
// Puts, direct writes and out-of-range accesses pass IDLE then EXEC; in-range
// reads add RWAIT for the registered read of the cell store behind the queue.
// Clear blanks every cell; a row advance past the last row scrolls the store.
// After reset a fill sweep over all COLUMNS*ROWS cells runs; in_full stays high.
// Two-entry queues before and after the back end absorb stalls on either side.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_attribute,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_cell_data,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcce_pkg::*;

  cmd_t    cmd_dec, cmd_head;
  result_t res_in, res_head;
  logic    cmd_full, cmd_empty, cmd_pop;
  logic    res_full, res_push;
  logic    init_busy;

  assign in_full   = cmd_full || init_busy;
  assign cfg_ready = 1'b1;

  tcce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .action    (in_action),
    .char_code (in_char_code),
    .column    (in_column),
    .row       (in_row),
    .attribute (in_attribute),
    .cmd       (cmd_dec)
  );

  tcce_fifo #(.DW($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .din   (cmd_dec),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd_in    (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .init_busy (init_busy)
  );

  tcce_fifo #(.DW($bits(result_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (out_pop),
    .dout  (res_head),
    .full  (res_full),
    .empty (out_empty)
  );

  assign out_cell_data     = res_head.cell_data;
  assign out_cursor_column = res_head.cursor_column;
  assign out_cursor_row    = res_head.cursor_row;
  assign out_cursor_offset = res_head.cursor_offset;
  assign out_out_of_range  = res_head.out_of_range;

endmodule

### hw/rtl/tcce_fifo.sv
// ----------------------------------------------------------------------------
// tcce_fifo
// Small register queue used between the front end, back end and result port.
// ----------------------------------------------------------------------------
module tcce_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### hw/rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Decodes an input transaction into a command: control character class,
// linear cell address and range flag.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic [1:0]    action,
  input  logic [7:0]    char_code,
  input  logic [7:0]    column,
  input  logic [4:0]    row,
  input  logic [7:0]    attribute,
  output tcce_pkg::cmd_t cmd
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [IN_AW-1:0] addr;
  logic             oor;

  assign addr = IN_AW'(row) * IN_AW'(COLUMNS) + IN_AW'(column);
  assign oor  = (addr >= IN_AW'(CELLS));

  always_comb begin
    cmd.ch   = char_code;
    cmd.attr = attribute;
    cmd.addr = addr[AW-1:0];
    cmd.oor  = 1'b0;
    cmd.kind = K_PRINT;
    case (action_t'(action))
      ACT_PUT: begin
        case (char_code)
          CH_NEWLINE: cmd.kind = K_NEWLINE;
          CH_CR:      cmd.kind = K_CR;
          CH_BS:      cmd.kind = K_BS;
          CH_TAB:     cmd.kind = K_TAB;
          default:    cmd.kind = K_PRINT;
        endcase
      end
      ACT_WRITE: begin
        cmd.kind = K_WRITE;
        cmd.oor  = oor;
      end
      ACT_CLEAR: cmd.kind = K_CLEAR;
      ACT_READ: begin
        cmd.kind = K_READ;
        cmd.oor  = oor;
      end
      default: cmd.kind = K_PRINT;
    endcase
  end

endmodule

### hw/rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Executes commands against the cell store and cursor: writes, reads,
// scroll copy walk and fill sweeps. Holds the text color register.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  tcce_pkg::cmd_t    cmd_in,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output tcce_pkg::result_t res,
  output logic              init_busy
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COPY = CW'(CELLS - COLUMNS - 1);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [7:0]        color_r;

  logic              we;
  logic [CW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, blank;
  logic              data_sel;
  logic              adv_row;
  logic [AW-1:0]     cur_addr;
  logic [COL_W:0]    col_inc, tab8;
  logic [ROW_W:0]    row_inc;
  logic [11:0]       off_full;

  assign init_busy = (state_r == ST_INIT);
  assign blank     = {color_r, CH_BLANK};
  assign cur_addr  = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign tab8      = ({1'b0, col_r} + 8'd8) & TAB_MASK;
  assign row_inc   = {1'b0, row_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ptr_nxt   = ptr_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    we        = 1'b0;
    waddr     = ptr_r;
    wdata     = blank;
    raddr     = ptr_r + CW'(COLUMNS + 1);
    data_sel  = 1'b0;
    adv_row   = 1'b0;
    case (state_r)
      ST_INIT: begin
        we      = 1'b1;
        wdata   = {RESET_COLOR, CH_BLANK};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        res_push  = 1'b1;
        case (cmd_r.kind)
          K_NEWLINE: begin
            col_nxt = '0;
            adv_row = 1'b1;
          end
          K_CR: col_nxt = '0;
          K_BS: begin
            if (col_r != '0) begin
              col_nxt = col_r - 1'b1;
              we      = 1'b1;
              waddr   = CW'(cur_addr - 1'b1);
            end
          end
          K_TAB: begin
            if (tab8 >= (COL_W + 1)'(COLUMNS)) begin
              col_nxt = '0;
              adv_row = 1'b1;
            end else begin
              col_nxt = tab8[COL_W-1:0];
            end
          end
          K_PRINT: begin
            we    = 1'b1;
            waddr = CW'(cur_addr);
            wdata = {color_r, cmd_r.ch};
            if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
              col_nxt = '0;
              adv_row = 1'b1;
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end
          K_WRITE: begin
            we    = !cmd_r.oor;
            waddr = cmd_r.addr[CW-1:0];
            wdata = {cmd_r.attr, cmd_r.ch};
          end
          K_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            ptr_nxt   = '0;
            res_push  = 1'b0;
            state_nxt = ST_FILL;
          end
          K_READ: begin
            raddr = cmd_r.addr[CW-1:0];
            if (!cmd_r.oor) begin
              res_push  = 1'b0;
              state_nxt = ST_RWAIT;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
        if (adv_row) begin
          if (row_inc >= (ROW_W + 1)'(ROWS)) begin
            row_nxt   = ROW_W'(ROWS - 1);
            ptr_nxt   = '0;
            raddr     = CW'(COLUMNS);
            res_push  = 1'b0;
            state_nxt = ST_SCROLL;
          end else begin
            row_nxt = row_inc[ROW_W-1:0];
          end
        end
      end
      ST_RWAIT: begin
        data_sel  = 1'b1;
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        we      = 1'b1;
        wdata   = rdata_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_COPY) begin
          state_nxt = ST_SFILL;
        end
      end
      ST_SFILL, ST_FILL: begin
        we      = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign off_full          = 12'(row_nxt) * 12'(COLUMNS) + 12'(col_nxt);
  assign res.cell_data     = data_sel ? rdata_r : '0;
  assign res.cursor_column = col_nxt;
  assign res.cursor_row    = row_nxt;
  assign res.cursor_offset = off_full[OFF_W-1:0];
  assign res.out_of_range  = cmd_r.oor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      col_r   <= '0;
      row_r   <= '0;
      ptr_r   <= '0;
      color_r <= RESET_COLOR;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_valid) begin
        color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
